/* design/ppsim_pkg.sv */
// Shared types and fixed-point widths for the plane pair similarity pipeline.
// No dependencies.
package ppsim_pkg;

    // Fraction bits of the plane slopes.
    localparam int SLOPE_FRAC_BITS = 12;

    // z and plane offset are aligned to the slope*coordinate scale by this shift.
    localparam int UP_SH = SLOPE_FRAC_BITS - 4;

    // Signed numerator: four terms, the largest a 33-bit product or a shifted offset.
    localparam int NUM_W = (((21 + UP_SH) > 33) ? (21 + UP_SH) : 33) + 2;
    // Signed denominator: two 32-bit products plus 2^(2F).
    localparam int DEN_W = (((2 * SLOPE_FRAC_BITS + 1) > 33) ? (2 * SLOPE_FRAC_BITS + 1) : 33) + 1;
    // Unsigned norm radicand before the 2^10 scaling.
    localparam int Q_W   = (((2 * SLOPE_FRAC_BITS) > 32) ? (2 * SLOPE_FRAC_BITS) : 32) + 1;
    // Square root: result width and (even) radicand width.
    localparam int RT_W  = (Q_W + 11) / 2;
    localparam int SQ_W  = 2 * RT_W;
    // Divider.
    localparam int SIM_W  = 24;
    localparam int QUO_W  = SIM_W;
    localparam int DIV_W  = DEN_W + 1;
    localparam int PROD_W = NUM_W + RT_W;
    localparam int CMP_W  = (PROD_W > (DIV_W + QUO_W)) ? PROD_W : (DIV_W + QUO_W);

    localparam logic signed [DEN_W-1:0] DEN_ONE = DEN_W'(1) << (2 * SLOPE_FRAC_BITS);
    localparam logic [Q_W-1:0]          Q_ONE   = Q_W'(1) << (2 * SLOPE_FRAC_BITS);
    localparam logic [SIM_W-1:0]        SIM_MAX = '1;

    typedef struct packed {
        logic [15:0] a_slope_x;
        logic [15:0] a_slope_y;
        logic [20:0] a_offset;
        logic [15:0] a_center_x;
        logic [15:0] a_center_y;
        logic [18:0] a_center_z;
        logic [15:0] b_slope_x;
        logic [15:0] b_slope_y;
        logic [20:0] b_offset;
        logic [15:0] b_center_x;
        logic [15:0] b_center_y;
        logic [18:0] b_center_z;
    } t_pair;

    typedef struct packed {
        logic [SIM_W-1:0] similarity;
        logic             degenerate;
    } t_sim;

    // Magnitudes of numerator and denominator of one distance term.
    typedef struct packed {
        logic [NUM_W-1:0] anum;
        logic [DEN_W-1:0] aden;
    } t_term;

    typedef t_term [1:0] t_terms;

endpackage

/* design/ppsim_in_if.sv */
// Request channel carrying one plane pair.
// Depends on ppsim_pkg.
interface ppsim_in_if;
    logic                 valid;
    logic                 ready;
    ppsim_pkg::t_pair     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ppsim_out_if.sv */
// Result channel carrying the similarity and degenerate flag.
// Depends on ppsim_pkg.
interface ppsim_out_if;
    logic                 valid;
    logic                 ready;
    ppsim_pkg::t_sim      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ppsim_front.sv */
// Front end: slope products, then numerator, denominator and norm radicand
// for both terms. Two register stages. Depends on ppsim_pkg.
module ppsim_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  ppsim_pkg::t_pair            i_pair,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ppsim_pkg::SQ_W-1:0]  o_sq [2],
    output ppsim_pkg::t_terms           o_terms
);
    localparam int NUM_W = ppsim_pkg::NUM_W;
    localparam int DEN_W = ppsim_pkg::DEN_W;
    localparam int Q_W   = ppsim_pkg::Q_W;
    localparam int SQ_W  = ppsim_pkg::SQ_W;
    localparam int UP_SH = ppsim_pkg::UP_SH;

    // term 0: normal of A, target plane B; term 1 swapped
    logic signed [15:0] w_nx [2];
    logic signed [15:0] w_ny [2];
    logic signed [15:0] w_px [2];
    logic signed [15:0] w_py [2];
    logic signed [20:0] w_pc [2];
    logic        [15:0] w_cx [2];
    logic        [15:0] w_cy [2];
    logic signed [18:0] w_cz [2];

    always_comb begin
        w_nx[0] = $signed(i_pair.a_slope_x);
        w_ny[0] = $signed(i_pair.a_slope_y);
        w_px[0] = $signed(i_pair.b_slope_x);
        w_py[0] = $signed(i_pair.b_slope_y);
        w_pc[0] = $signed(i_pair.b_offset);
        w_cx[0] = i_pair.a_center_x;
        w_cy[0] = i_pair.a_center_y;
        w_cz[0] = $signed(i_pair.a_center_z);
        w_nx[1] = $signed(i_pair.b_slope_x);
        w_ny[1] = $signed(i_pair.b_slope_y);
        w_px[1] = $signed(i_pair.a_slope_x);
        w_py[1] = $signed(i_pair.a_slope_y);
        w_pc[1] = $signed(i_pair.a_offset);
        w_cx[1] = i_pair.b_center_x;
        w_cy[1] = i_pair.b_center_y;
        w_cz[1] = $signed(i_pair.b_center_z);
    end

    logic               r_v1;
    logic               r_v2;
    logic               w_rdy1;
    logic               w_rdy2;
    logic signed [32:0] r_pxcx [2];
    logic signed [32:0] r_pycy [2];
    logic signed [31:0] r_pxnx [2];
    logic signed [31:0] r_pyny [2];
    logic signed [31:0] r_nx2  [2];
    logic signed [31:0] r_ny2  [2];
    logic signed [18:0] r_cz   [2];
    logic signed [20:0] r_pc   [2];
    logic [Q_W-1:0]     r_q    [2];
    ppsim_pkg::t_terms  r_terms;

    logic signed [NUM_W-1:0] n_num [2];
    logic signed [DEN_W-1:0] n_den [2];
    logic [Q_W-1:0]          n_q   [2];
    ppsim_pkg::t_terms       n_terms;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            for (int g = 0; g < 2; g++) begin
                r_pxcx[g] <= w_px[g] * $signed({1'b0, w_cx[g]});
                r_pycy[g] <= w_py[g] * $signed({1'b0, w_cy[g]});
                r_pxnx[g] <= w_px[g] * w_nx[g];
                r_pyny[g] <= w_py[g] * w_ny[g];
                r_nx2[g]  <= w_nx[g] * w_nx[g];
                r_ny2[g]  <= w_ny[g] * w_ny[g];
                r_cz[g]   <= w_cz[g];
                r_pc[g]   <= w_pc[g];
            end
        end
    end

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            n_num[g] = (NUM_W'(r_cz[g]) <<< UP_SH) - NUM_W'(r_pxcx[g]) - NUM_W'(r_pycy[g])
                     - (NUM_W'(r_pc[g]) <<< UP_SH);
            n_den[g] = DEN_W'(r_pxnx[g]) + DEN_W'(r_pyny[g]) + ppsim_pkg::DEN_ONE;
            n_q[g]   = Q_W'($unsigned(r_nx2[g])) + Q_W'($unsigned(r_ny2[g])) + ppsim_pkg::Q_ONE;
            n_terms[g].anum = n_num[g][NUM_W-1] ? $unsigned(-n_num[g]) : $unsigned(n_num[g]);
            n_terms[g].aden = n_den[g][DEN_W-1] ? $unsigned(-n_den[g]) : $unsigned(n_den[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_q     <= n_q;
            r_terms <= n_terms;
        end
    end

    always_comb begin
        for (int g = 0; g < 2; g++) begin
            o_sq[g] = SQ_W'({r_q[g], 10'b0});
        end
    end
    assign o_terms = r_terms;

endmodule

/* design/ppsim_sqrt.sv */
// Pipelined integer square root of the two norm radicands, one root bit
// per stage; carries the term magnitudes alongside. Depends on ppsim_pkg.
module ppsim_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ppsim_pkg::SQ_W-1:0]  i_sq [2],
    input  ppsim_pkg::t_terms           i_terms,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ppsim_pkg::RT_W-1:0]  o_root [2],
    output ppsim_pkg::t_terms           o_terms
);
    localparam int RT_W = ppsim_pkg::RT_W;
    localparam int SQ_W = ppsim_pkg::SQ_W;

    logic [SQ_W-1:0]   r_rem  [RT_W][2];
    logic [RT_W-1:0]   r_root [RT_W][2];
    ppsim_pkg::t_terms r_pay  [RT_W];
    logic              r_v    [RT_W];

    logic [SQ_W-1:0]   s_rem  [RT_W+1][2];
    logic [RT_W-1:0]   s_root [RT_W+1][2];
    ppsim_pkg::t_terms s_pay  [RT_W+1];
    logic              s_v    [RT_W+1];
    logic              w_rdy  [RT_W+1];

    assign s_v[0]       = i_valid;
    assign s_pay[0]     = i_terms;
    assign s_rem[0][0]  = i_sq[0];
    assign s_rem[0][1]  = i_sq[1];
    assign s_root[0][0] = '0;
    assign s_root[0][1] = '0;
    assign w_rdy[RT_W]  = i_ready;

    genvar k;
    for (k = 0; k < RT_W; k++) begin : g_stage
        localparam int BIT = RT_W - 1 - k;
        logic [SQ_W-1:0] w_trial [2];
        logic [SQ_W-1:0] n_rem   [2];
        logic [RT_W-1:0] n_root  [2];

        always_comb begin
            for (int t = 0; t < 2; t++) begin
                w_trial[t] = (SQ_W'(s_root[k][t]) << (BIT + 1)) | (SQ_W'(1) << (2 * BIT));
                if (s_rem[k][t] >= w_trial[t]) begin
                    n_rem[t]  = s_rem[k][t] - w_trial[t];
                    n_root[t] = s_root[k][t] | (RT_W'(1) << BIT);
                end else begin
                    n_rem[t]  = s_rem[k][t];
                    n_root[t] = s_root[k][t];
                end
            end
        end

        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && s_v[k]) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_pay[k]  <= s_pay[k];
            end
        end

        assign s_v[k+1]       = r_v[k];
        assign s_pay[k+1]     = r_pay[k];
        assign s_rem[k+1][0]  = r_rem[k][0];
        assign s_rem[k+1][1]  = r_rem[k][1];
        assign s_root[k+1][0] = r_root[k][0];
        assign s_root[k+1][1] = r_root[k][1];
    end

    assign o_ready   = w_rdy[0];
    assign o_valid   = s_v[RT_W];
    assign o_root[0] = s_root[RT_W][0];
    assign o_root[1] = s_root[RT_W][1];
    assign o_terms   = s_pay[RT_W];

    // floor root: leftover radicand never exceeds twice the root
    a_root_floor0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_v[RT_W] |-> s_rem[RT_W][0] <= (SQ_W'(s_root[RT_W][0]) << 1))
        else $error("sqrt remainder too large, term 0");
    a_root_floor1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_v[RT_W] |-> s_rem[RT_W][1] <= (SQ_W'(s_root[RT_W][1]) << 1))
        else $error("sqrt remainder too large, term 1");

endmodule

/* design/ppsim_div.sv */
// Multiply numerator by norm, then restoring divide by twice the denominator,
// one quotient bit per stage, with an up-front overflow check. Depends on ppsim_pkg.
module ppsim_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ppsim_pkg::RT_W-1:0]   i_root [2],
    input  ppsim_pkg::t_terms            i_terms,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ppsim_pkg::QUO_W-1:0]  o_quo [2],
    output logic                         o_bad [2]
);
    localparam int CMP_W = ppsim_pkg::CMP_W;
    localparam int DIV_W = ppsim_pkg::DIV_W;
    localparam int QUO_W = ppsim_pkg::QUO_W;
    // multiply, overflow check, then one stage per quotient bit
    localparam int NST   = QUO_W + 2;

    logic [CMP_W-1:0]  r_rem [NST][2];
    logic [DIV_W-1:0]  r_dvs [NST][2];
    logic [QUO_W-1:0]  r_quo [NST][2];
    logic              r_bad [NST][2];
    logic              r_v   [NST];
    logic              w_rdy [NST+1];

    assign w_rdy[NST] = i_ready;

    genvar j;
    for (j = 0; j < NST; j++) begin : g_stage
        logic [CMP_W-1:0] n_rem [2];
        logic [DIV_W-1:0] n_dvs [2];
        logic [QUO_W-1:0] n_quo [2];
        logic             n_bad [2];
        logic             w_vin;

        if (j == 0) begin : g_mul
            assign w_vin = i_valid;
            always_comb begin
                for (int t = 0; t < 2; t++) begin
                    n_rem[t] = CMP_W'(i_terms[t].anum) * CMP_W'(i_root[t]);
                    n_dvs[t] = {i_terms[t].aden, 1'b0};
                    n_quo[t] = '0;
                    n_bad[t] = 1'b0;
                end
            end
        end else if (j == 1) begin : g_check
            // quotient of 2^QUO_W or more saturates; a zero divisor lands here too
            assign w_vin = r_v[j-1];
            always_comb begin
                for (int t = 0; t < 2; t++) begin
                    n_rem[t] = r_rem[j-1][t];
                    n_dvs[t] = r_dvs[j-1][t];
                    n_quo[t] = '0;
                    n_bad[t] = r_rem[j-1][t] >= (CMP_W'(r_dvs[j-1][t]) << QUO_W);
                end
            end
        end else begin : g_step
            localparam int BIT = QUO_W + 1 - j;
            logic [CMP_W-1:0] w_trial [2];
            assign w_vin = r_v[j-1];
            always_comb begin
                for (int t = 0; t < 2; t++) begin
                    w_trial[t] = CMP_W'(r_dvs[j-1][t]) << BIT;
                    n_dvs[t]   = r_dvs[j-1][t];
                    n_bad[t]   = r_bad[j-1][t];
                    if (r_rem[j-1][t] >= w_trial[t]) begin
                        n_rem[t] = r_rem[j-1][t] - w_trial[t];
                        n_quo[t] = r_quo[j-1][t] | (QUO_W'(1) << BIT);
                    end else begin
                        n_rem[t] = r_rem[j-1][t];
                        n_quo[t] = r_quo[j-1][t];
                    end
                end
            end
        end

        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j] && w_vin) begin
                r_rem[j] <= n_rem;
                r_dvs[j] <= n_dvs;
                r_quo[j] <= n_quo;
                r_bad[j] <= n_bad;
            end
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[NST-1];
    assign o_quo[0] = r_quo[NST-1][0];
    assign o_quo[1] = r_quo[NST-1][1];
    assign o_bad[0] = r_bad[NST-1][0];
    assign o_bad[1] = r_bad[NST-1][1];

    // a finished, non-saturated division leaves less than one divisor behind
    a_div_rem0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !r_bad[NST-1][0]) |-> r_rem[NST-1][0] < CMP_W'(r_dvs[NST-1][0]))
        else $error("divider remainder not reduced, term 0");
    a_div_rem1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !r_bad[NST-1][1]) |-> r_rem[NST-1][1] < CMP_W'(r_dvs[NST-1][1]))
        else $error("divider remainder not reduced, term 1");

endmodule

/* design/plane_pair_similarity_top.sv */
// Channel   Dir  Payload                              Handshake
// i_pair    in   planes A/B, centroids A/B (t_pair)   valid/ready
// o_sim     out  similarity Q19.5, degenerate flag    valid/ready
//
// One request per cycle sustained while o_sim accepts results; the pipeline depth
// is set by the bit-per-stage root and divider.
// Every stage holds its own valid bit and stalls only when full and blocked
// downstream, so a waiting result stops new requests only once every stage is full.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on ppsim_pkg, ppsim_in_if, ppsim_out_if, ppsim_front, ppsim_sqrt, ppsim_div.
module plane_pair_similarity_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppsim_in_if.sink    i_pair,
    ppsim_out_if.source o_sim
);
    localparam int SQ_W  = ppsim_pkg::SQ_W;
    localparam int RT_W  = ppsim_pkg::RT_W;
    localparam int QUO_W = ppsim_pkg::QUO_W;
    localparam int SIM_W = ppsim_pkg::SIM_W;

    logic              w_f_valid;
    logic              w_f_ready;
    logic [SQ_W-1:0]   w_f_sq [2];
    ppsim_pkg::t_terms w_f_terms;

    logic              w_s_valid;
    logic              w_s_ready;
    logic [RT_W-1:0]   w_s_root [2];
    ppsim_pkg::t_terms w_s_terms;

    logic              w_d_valid;
    logic              w_d_ready;
    logic [QUO_W-1:0]  w_d_quo [2];
    logic              w_d_bad [2];

    ppsim_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pair.valid),
        .o_ready (i_pair.ready),
        .i_pair  (i_pair.data),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_sq    (w_f_sq),
        .o_terms (w_f_terms)
    );

    ppsim_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_sq    (w_f_sq),
        .i_terms (w_f_terms),
        .o_valid (w_s_valid),
        .i_ready (w_s_ready),
        .o_root  (w_s_root),
        .o_terms (w_s_terms)
    );

    ppsim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .o_ready (w_s_ready),
        .i_root  (w_s_root),
        .i_terms (w_s_terms),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_quo   (w_d_quo),
        .o_bad   (w_d_bad)
    );

    // output register: sum of both terms with saturation
    logic              r_out_v;
    ppsim_pkg::t_sim   r_out;
    ppsim_pkg::t_sim   n_out;
    logic [SIM_W:0]    w_sum;

    assign w_d_ready = !r_out_v || o_sim.ready;

    always_comb begin
        w_sum = {1'b0, w_d_quo[0]} + {1'b0, w_d_quo[1]};
        n_out.degenerate = w_d_bad[0] || w_d_bad[1] || w_sum[SIM_W];
        n_out.similarity = n_out.degenerate ? ppsim_pkg::SIM_MAX : w_sum[SIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_d_ready) begin
            r_out_v <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready && w_d_valid) begin
            r_out <= n_out;
        end
    end

    assign o_sim.valid = r_out_v;
    assign o_sim.data  = r_out;

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.degenerate) |-> r_out.similarity == ppsim_pkg::SIM_MAX)
        else $error("degenerate result not saturated");

endmodule

/* sim/tb.sv */
// Self-checking regression for plane_pair_similarity_top: drives plane pairs, predicts
// similarity and degenerate flag from an independent fixed-point model, checks each result.
// Depends on ppsim_pkg, ppsim_in_if, ppsim_out_if and the design.
module tb;
    localparam int F = ppsim_pkg::SLOPE_FRAC_BITS;
    localparam int LATENCY = 2 + ppsim_pkg::RT_W + ppsim_pkg::QUO_W + 3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PAIR_W = $bits(ppsim_pkg::t_pair);
    localparam logic [63:0] SAT = 64'd16777215;

    logic i_clk;
    logic i_rst_n;

    ppsim_in_if  pair_ch();
    ppsim_out_if sim_ch();

    plane_pair_similarity_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pair (pair_ch.sink),
        .o_sim  (sim_ch.source)
    );

    ppsim_pkg::t_sim expected_sims[$];
    int   mismatches;
    int   idle_cycles;
    int   send_idle_pct;
    int   recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= v) r = b;
        end
        return r;
    endfunction

    // One cutting distance; all products fit in signed 64 bits
    function automatic logic [63:0] cut_distance(
        longint nx, longint ny, longint px, longint py, longint pc,
        longint cx, longint cy, longint cz, ref bit flag);
        longint num;
        longint den;
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0] anum;
        logic [63:0] aden;
        logic [63:0] nrm;
        num = cz * (64'sd1 <<< (F - 4)) - px * cx - py * cy - pc * (64'sd1 <<< (F - 4));
        den = px * nx + py * ny + (64'sd1 <<< (2 * F));
        anum = (num < 0) ? -num : num;
        aden = (den < 0) ? -den : den;
        nrm = root_floor((nx * nx + ny * ny + (64'sd1 <<< (2 * F))) << 10);
        if (aden == 0) begin
            flag = 1'b1;
            return SAT;
        end
        prod = {64'd0, anum} * {64'd0, nrm};
        quo = prod / {63'd0, aden, 1'b0};
        if (quo > SAT) begin
            flag = 1'b1;
            return SAT;
        end
        return quo[63:0];
    endfunction

    function automatic ppsim_pkg::t_sim predict_similarity(ppsim_pkg::t_pair p);
        ppsim_pkg::t_sim r;
        bit flag;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] total;
        flag = 1'b0;
        t1 = cut_distance($signed(p.a_slope_x), $signed(p.a_slope_y),
            $signed(p.b_slope_x), $signed(p.b_slope_y), $signed(p.b_offset),
            p.a_center_x, p.a_center_y, $signed(p.a_center_z), flag);
        t2 = cut_distance($signed(p.b_slope_x), $signed(p.b_slope_y),
            $signed(p.a_slope_x), $signed(p.a_slope_y), $signed(p.a_offset),
            p.b_center_x, p.b_center_y, $signed(p.b_center_z), flag);
        total = t1 + t2;
        if (flag || total > SAT) begin
            total = SAT;
            flag = 1'b1;
        end
        r.similarity = total[23:0];
        r.degenerate = flag;
        return r;
    endfunction

    // valid stays high after the last request until stop_sending or the next idle
    task automatic send_pair(ppsim_pkg::t_pair p);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            pair_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.data  <= p;
        @(posedge i_clk);
        while (!pair_ch.ready) @(posedge i_clk);
        expected_sims.insert(expected_sims.size(), predict_similarity(p));
    endtask

    task automatic stop_sending();
        pair_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stall and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sim_ch.ready <= 1'b0;
        end else begin
            if (sim_ch.valid && sim_ch.ready) begin
                if (expected_sims.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result sim=%0d deg=%0b",
                            sim_ch.data.similarity, sim_ch.data.degenerate);
                end else begin
                    ppsim_pkg::t_sim e;
                    e = expected_sims.pop_front();
                    if (e.similarity !== sim_ch.data.similarity
                            || e.degenerate !== sim_ch.data.degenerate) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp sim=%0d deg=%0b got sim=%0d deg=%0b",
                                e.similarity, e.degenerate,
                                sim_ch.data.similarity, sim_ch.data.degenerate);
                    end
                end
            end
            sim_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any request or result moving
    always @(posedge i_clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (sim_ch.valid && sim_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("plane_pair_similarity_top regression: fail");
            $finish;
        end
    end

    function automatic ppsim_pkg::t_pair random_pair();
        ppsim_pkg::t_pair p;
        p = PAIR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return p;
    endfunction

    // Mostly small slopes so the distances stay in range
    function automatic ppsim_pkg::t_pair plausible_pair();
        ppsim_pkg::t_pair p;
        p = random_pair();
        p.a_slope_x  = 16'($signed($urandom_range(2048, 0)) - 1024);
        p.a_slope_y  = 16'($signed($urandom_range(2048, 0)) - 1024);
        p.b_slope_x  = 16'($signed($urandom_range(2048, 0)) - 1024);
        p.b_slope_y  = 16'($signed($urandom_range(2048, 0)) - 1024);
        p.a_center_x = 16'($urandom_range(10240, 0));
        p.a_center_y = 16'($urandom_range(7680, 0));
        p.b_center_x = 16'($urandom_range(10240, 0));
        p.b_center_y = 16'($urandom_range(7680, 0));
        p.a_offset   = 21'($signed($urandom_range(65536, 0)) - 32768);
        p.b_offset   = 21'($signed($urandom_range(65536, 0)) - 32768);
        p.a_center_z = 19'($signed($urandom_range(32768, 0)) - 16384);
        p.b_center_z = 19'($signed($urandom_range(32768, 0)) - 16384);
        return p;
    endfunction

    task automatic test_directed();
        ppsim_pkg::t_pair p;
        // identical planes through centroids: zero distance
        p = '0;
        send_pair(p);
        // all ones
        send_pair('1);
        // extremes of every field
        p = '0;
        p.a_slope_x = 16'h8000; p.a_slope_y = 16'h7FFF; p.a_offset = 21'h100000;
        p.a_center_x = 16'hFFFF; p.a_center_y = 16'hFFFF; p.a_center_z = 19'h3FFFF;
        p.b_slope_x = 16'h7FFF; p.b_slope_y = 16'h8000; p.b_offset = 21'h0FFFFF;
        p.b_center_z = 19'h40000;
        send_pair(p);
        // zero denominator: B_x*A_x = -2^24 with y terms zero
        p = '0;
        p.a_slope_x = 16'h1000; p.b_slope_x = 16'hF000;
        send_pair(p);
        // zero denominator on both terms via y slopes
        p = '0;
        p.a_slope_y = 16'h2000; p.b_slope_y = 16'hF800;
        send_pair(p);
        // small offset difference: small nonzero similarity
        p = '0;
        p.b_offset = 21'd256;
        send_pair(p);
        p.b_offset = 21'h1FFF00;
        send_pair(p);
        // large offset separation, still below saturation
        p = '0;
        p.a_offset = 21'h0FFFFF; p.b_offset = 21'h100000;
        send_pair(p);
        for (int i = 0; i < 12; i++) begin
            p = random_pair();
            send_pair(p);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9, 0) < 8)
                send_pair(plausible_pair());
            else
                send_pair(random_pair());
        end
    endtask

    task automatic test_drain_pause();
        stop_sending();
        while (expected_sims.size() != 0) @(posedge i_clk);
        test_random(20);
    endtask

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        send_idle_pct = 20;
        recv_idle_pct = 88;
        i_rst_n       = 1'b0;
        pair_ch.valid = 1'b0;
        pair_ch.data  = '0;
        sim_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(180);
        send_idle_pct = 88;
        recv_idle_pct = 20;
        test_random(180);
        test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        stop_sending();
        while (expected_sims.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("plane_pair_similarity_top regression: pass");
        else
            $display("plane_pair_similarity_top regression: fail");
        $finish;
    end
endmodule
